// ----- hw/rtl/obd_pkg.sv -----
// shared types, constants and register map of the one-bit audio decimator
`default_nettype none
package obd_pkg;

    // fixed point
    localparam int unsigned FRAC_W = 16;
    localparam int unsigned ACC_W  = 26;
    localparam logic [ACC_W-1:0] Q_ONE = ACC_W'(1) << FRAC_W;

    // register widths and reset values
    localparam int unsigned TPS_W   = 24;
    localparam int unsigned GAIN_W  = 15;
    localparam int unsigned FILL_W  = 10;
    localparam int unsigned SIL_W   = 16;
    localparam logic [TPS_W-1:0]  TPS_RST  = 24'd1783292;
    localparam logic [GAIN_W-1:0] GAIN_RST = 15'd8192;
    localparam logic [FILL_W-1:0] FILL_RST = 10'd256;

    // sample store
    localparam int unsigned FIFO_DEPTH_DEF = 1024;
    localparam int unsigned ENTRY_W        = 16;
    localparam int unsigned LEVEL_W        = 15;
    localparam int unsigned PROD_W         = ACC_W + GAIN_W;

    // apb register map
    localparam int unsigned APB_AW = 4;
    localparam int unsigned APB_DW = 32;
    localparam logic [1:0] REG_TPS  = 2'd0;
    localparam logic [1:0] REG_GAIN = 2'd1;
    localparam logic [1:0] REG_FILL = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_REAL     = 2'd0;
    localparam logic [1:0] KIND_SCHED    = 2'd1;
    localparam logic [1:0] KIND_UNDERRUN = 2'd2;

    // request kinds
    localparam logic REQ_TICK   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef struct packed {
        logic [TPS_W-1:0]  ticks_per_sample;
        logic [GAIN_W-1:0] output_gain;
        logic [FILL_W-1:0] fill_block;
    } t_cfg;

endpackage
`default_nettype wire

// ----- hw/rtl/obd_regs.sv -----
// apb configuration registers
`default_nettype none
module obd_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [obd_pkg::APB_AW-1:0]  paddr,
    input  wire logic [obd_pkg::APB_DW-1:0]  pwdata,
    output logic      [obd_pkg::APB_DW-1:0]  prdata,
    output logic                             pready,
    output obd_pkg::t_cfg                    o_cfg
);
    import obd_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ticks_per_sample <= TPS_RST;
            r_cfg.output_gain      <= GAIN_RST;
            r_cfg.fill_block       <= FILL_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_TPS:  r_cfg.ticks_per_sample <= pwdata[TPS_W-1:0];
                REG_GAIN: r_cfg.output_gain      <= pwdata[GAIN_W-1:0];
                REG_FILL: r_cfg.fill_block       <= pwdata[FILL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_TPS:  prdata = {{(APB_DW-TPS_W){1'b0}}, r_cfg.ticks_per_sample};
            REG_GAIN: prdata = {{(APB_DW-GAIN_W){1'b0}}, r_cfg.output_gain};
            REG_FILL: prdata = {{(APB_DW-FILL_W){1'b0}}, r_cfg.fill_block};
            default:  prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ----- hw/rtl/obd_level_unit.sv -----
// window average: one multiply then a restoring divide, one quotient bit per cycle
`default_nettype none
module obd_level_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [obd_pkg::ACC_W-1:0]    i_sum,
    input  wire logic [obd_pkg::ACC_W-1:0]    i_weight,
    input  wire logic [obd_pkg::GAIN_W-1:0]   i_gain,
    output logic                              o_done,
    output logic      [obd_pkg::LEVEL_W-1:0]  o_level
);
    import obd_pkg::*;

    typedef enum logic [3:0] {
        LV_IDLE = 4'b0001,
        LV_MUL  = 4'b0010,
        LV_LOAD = 4'b0100,
        LV_DIV  = 4'b1000
    } t_lv_state;

    localparam int unsigned CNT_W = $clog2(LEVEL_W);

    t_lv_state            r_state;
    logic [ACC_W-1:0]     r_sum;
    logic [ACC_W-1:0]     r_w;
    logic [GAIN_W-1:0]    r_gain;
    logic [PROD_W-1:0]    r_prod;
    logic [ACC_W-1:0]     r_rem;
    logic [LEVEL_W-1:0]   r_low;
    logic [LEVEL_W-1:0]   r_q;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_done;

    logic [ACC_W:0]       trial;
    logic                 fits;
    logic [ACC_W:0]       diff;

    // the average never exceeds the gain, so the upper product bits are below the weight
    assign trial = {r_rem, r_low[LEVEL_W-1]};
    assign fits  = trial >= {1'b0, r_w};
    assign diff  = trial - {1'b0, r_w};

    assign o_done  = r_done;
    assign o_level = (r_w == '0) ? '0 : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LV_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= (r_state == LV_DIV) && (r_cnt == CNT_W'(LEVEL_W - 1));
            unique case (r_state)
                LV_IDLE: begin
                    if (i_start) begin
                        r_state <= LV_MUL;
                    end
                end
                LV_MUL: begin
                    r_state <= LV_LOAD;
                end
                LV_LOAD: begin
                    r_cnt   <= '0;
                    r_state <= LV_DIV;
                end
                LV_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(LEVEL_W - 1)) begin
                        r_state <= LV_IDLE;
                    end
                end
                default: r_state <= LV_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == LV_IDLE && i_start) begin
            r_sum  <= i_sum;
            r_w    <= i_weight;
            r_gain <= i_gain;
        end
        if (r_state == LV_MUL) begin
            r_prod <= {{GAIN_W{1'b0}}, r_sum} * {{ACC_W{1'b0}}, r_gain};
        end
        if (r_state == LV_LOAD) begin
            r_rem <= r_prod[PROD_W-1:LEVEL_W];
            r_low <= r_prod[LEVEL_W-1:0];
            r_q   <= '0;
        end
        if (r_state == LV_DIV) begin
            r_rem <= fits ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
            r_low <= {r_low[LEVEL_W-2:0], 1'b0};
            r_q   <= {r_q[LEVEL_W-2:0], fits};
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/obd_sample_ram.sv -----
// sample store: one write port, one read port with registered data
`default_nettype none
module obd_sample_ram #(
    parameter int unsigned DEPTH = obd_pkg::FIFO_DEPTH_DEF,
    parameter int unsigned WIDTH = obd_pkg::ENTRY_W
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/one_bit_audio_decimator_fifo.sv -----
// top level: tick accumulator, sample fifo control and stream ports
// a tick that does not close a window leaves the block idle; a tick that closes
// a window keeps the block busy through one multiply, a load, 15 divide steps in the level
// unit and the store write; a request answers silence in the next cycle, or a stored
// sample after the registered ram read; results wait in an output register
// synchronous active-low reset clears the accumulator and pointers, sets the silence count
// to the reset fill; the sample store is not cleared and needs no clearing pass
`default_nettype none
module one_bit_audio_decimator_fifo #(
    parameter int unsigned FIFO_DEPTH = obd_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // stream in
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [7:0]                  s_axis_tdata,  // [0] beeper_bit
    input  wire logic [0:0]                  s_axis_tuser,  // [0] req_type
    // stream out
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic      [15:0]                 m_axis_tdata,  // [14:0] pcm_sample
    output logic      [1:0]                  m_axis_tuser,  // [1:0] fill_kind
    // apb
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [obd_pkg::APB_AW-1:0]  paddr,
    input  wire logic [obd_pkg::APB_DW-1:0]  pwdata,
    output logic      [obd_pkg::APB_DW-1:0]  prdata,
    output logic                             pready
);
    import obd_pkg::*;

    localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_READ = 3'b100
    } t_state;

    t_cfg                cfg;
    t_state              r_state;
    logic [ACC_W-1:0]    r_count;
    logic [ACC_W-1:0]    r_sum;
    logic [ACC_W-1:0]    r_w;
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [SIL_W-1:0]    r_silence;
    logic                r_out_valid;
    logic [LEVEL_W-1:0]  r_out_level;
    logic [1:0]          r_out_kind;

    logic                in_acc;
    logic                is_req;
    logic                bit_in;
    logic                closes;
    logic [ACC_W-1:0]    frac;
    logic [ACC_W-1:0]    sum_close;
    logic [ACC_W-1:0]    w_close;
    logic [ACC_W-1:0]    w_open;
    logic [ACC_W-1:0]    step;
    logic                lvl_start;
    logic                lvl_done;
    logic [LEVEL_W-1:0]  lvl_level;
    logic                fifo_empty;
    logic                rd_en;
    logic [ENTRY_W-1:0]  rd_data;
    logic                out_load;

    obd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign is_req = s_axis_tuser[0] == REQ_SAMPLE;
    assign bit_in = s_axis_tdata[0];

    // a request needs the output register free by the time its result is ready
    assign s_axis_tready = (r_state == ST_IDLE) &&
                           (!is_req || !r_out_valid || m_axis_tready);
    assign in_acc = s_axis_tvalid & s_axis_tready;

    // window close: countdown went negative, split the current tick
    assign closes    = r_count[ACC_W-1];
    assign frac      = r_count + Q_ONE;
    assign sum_close = r_sum + (bit_in ? frac : '0);
    assign w_close   = r_w + frac;
    assign w_open    = Q_ONE - r_count;
    assign step      = (cfg.ticks_per_sample < TPS_W'(Q_ONE)) ?
                       Q_ONE : {{(ACC_W-TPS_W){1'b0}}, cfg.ticks_per_sample};

    assign lvl_start  = in_acc && !is_req && closes;
    assign fifo_empty = r_rd_ptr == r_wr_ptr;
    assign rd_en      = in_acc && is_req && (r_silence == '0) && !fifo_empty;

    // silence answers at once, a stored sample after the ram read
    assign out_load   = (in_acc && is_req && ((r_silence != '0) || fifo_empty)) ||
                        (r_state == ST_READ);

    obd_level_unit u_level (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (lvl_start),
        .i_sum    (sum_close),
        .i_weight (w_close),
        .i_gain   (cfg.output_gain),
        .o_done   (lvl_done),
        .o_level  (lvl_level)
    );

    obd_sample_ram #(
        .DEPTH (FIFO_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (lvl_done),
        .i_wr_addr (r_wr_ptr),
        .i_wr_data ({{(ENTRY_W-LEVEL_W){1'b0}}, lvl_level}),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_w         <= '0;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_silence   <= SIL_W'(FILL_RST);
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc && !is_req) begin
                        if (closes) begin
                            r_w     <= w_open;
                            r_sum   <= bit_in ? w_open : '0;
                            r_count <= r_count + step - Q_ONE;
                            r_state <= ST_CALC;
                        end else begin
                            r_w     <= r_w + Q_ONE;
                            r_sum   <= r_sum + (bit_in ? Q_ONE : '0);
                            r_count <= r_count - Q_ONE;
                        end
                    end else if (in_acc) begin
                        if (r_silence != '0) begin
                            r_silence   <= r_silence - 1'b1;
                            r_out_level <= '0;
                            r_out_kind  <= KIND_SCHED;
                        end else if (fifo_empty) begin
                            r_silence   <= r_silence + {{(SIL_W-FILL_W){1'b0}}, cfg.fill_block};
                            r_out_level <= '0;
                            r_out_kind  <= KIND_UNDERRUN;
                        end else begin
                            r_rd_ptr <= r_rd_ptr + 1'b1;
                            r_state  <= ST_READ;
                        end
                    end
                end
                ST_CALC: begin
                    if (lvl_done) begin
                        r_wr_ptr <= r_wr_ptr + 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                ST_READ: begin
                    r_out_level <= rd_data[LEVEL_W-1:0];
                    r_out_kind  <= KIND_REAL;
                    r_state     <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_level};
    assign m_axis_tuser  = r_out_kind;

endmodule
`default_nettype wire

// ----- sim/obd_pcm_checker.sv -----
// checker for the one-bit audio decimator: predicts the pcm stream and compares it
`timescale 1ns / 1ps
module obd_pcm_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_s_tvalid,
    input  wire logic                       i_s_tready,
    input  wire logic [7:0]                 i_s_tdata,   // [0] beeper_bit
    input  wire logic [0:0]                 i_s_tuser,   // [0] req_type
    input  wire logic                       i_m_tvalid,
    input  wire logic                       i_m_tready,
    input  wire logic [15:0]                i_m_tdata,   // [14:0] pcm_sample
    input  wire logic [1:0]                 i_m_tuser,   // [1:0] fill_kind
    input  wire logic                       i_psel,
    input  wire logic                       i_penable,
    input  wire logic                       i_pwrite,
    input  wire logic [obd_pkg::APB_AW-1:0] i_paddr,
    input  wire logic [obd_pkg::APB_DW-1:0] i_pwdata,
    input  wire logic [obd_pkg::APB_DW-1:0] i_prdata,
    input  wire logic                       i_pready,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_window_count,
    output int                              o_overrun_count,
    output int                              o_real_count,
    output int                              o_sched_count,
    output int                              o_underrun_count
);
    import obd_pkg::*;

    localparam int unsigned PTR_W   = $clog2(FIFO_DEPTH_DEF);
    localparam longint      ONE_Q16 = longint'(Q_ONE);

    typedef struct packed {
        logic [LEVEL_W-1:0] pcm;
        logic [1:0]         kind;
    } t_pcm_result;

    t_pcm_result        pcm_expected[$];

    logic [TPS_W-1:0]   cfg_tps;
    logic [GAIN_W-1:0]  cfg_gain;
    logic [FILL_W-1:0]  cfg_fill;

    longint             countdown;
    longint             ones_sum;
    longint             weight_sum;
    logic [ENTRY_W-1:0] level_ram [FIFO_DEPTH_DEF];
    logic [PTR_W-1:0]   wr_ptr;
    logic [PTR_W-1:0]   rd_ptr;
    logic [SIL_W-1:0]   silence_cnt;

    int                 fail_count;
    int                 window_count;
    int                 overrun_count;
    int                 real_count;
    int                 sched_count;
    int                 underrun_count;

    // the tick that ends a window is split between the closing and the next window
    task automatic close_window(input longint beep);
        longint             frac;
        longint             step;
        logic [ENTRY_W-1:0] level;
        frac = countdown + ONE_Q16;
        step = (longint'(cfg_tps) < ONE_Q16) ? ONE_Q16 : longint'(cfg_tps);
        ones_sum   += beep * frac;
        weight_sum += frac;
        level = '0;
        if (weight_sum > 0 && ones_sum >= 0)
            level = ENTRY_W'((ones_sum * longint'(cfg_gain)) / weight_sum);
        level_ram[wr_ptr] = level;
        wr_ptr = wr_ptr + 1'b1;
        window_count++;
        if (wr_ptr == rd_ptr)
            overrun_count++;
        weight_sum = -countdown;
        ones_sum   = beep * weight_sum;
        countdown += step;
    endtask

    task automatic decimate_tick(input logic beeper_bit);
        longint beep;
        beep = beeper_bit ? 64'sd1 : 64'sd0;
        if (countdown < 0)
            close_window(beep);
        ones_sum   += beep * ONE_Q16;
        countdown  -= ONE_Q16;
        weight_sum += ONE_Q16;
    endtask

    task automatic serve_request(output t_pcm_result res);
        res.pcm = '0;
        if (silence_cnt != '0) begin
            silence_cnt = silence_cnt - 1'b1;
            res.kind = KIND_SCHED;
            sched_count++;
        end else if (rd_ptr == wr_ptr) begin
            silence_cnt = silence_cnt + SIL_W'(cfg_fill);
            res.kind = KIND_UNDERRUN;
            underrun_count++;
        end else begin
            res.pcm  = level_ram[rd_ptr][LEVEL_W-1:0];
            res.kind = KIND_REAL;
            rd_ptr = rd_ptr + 1'b1;
            real_count++;
        end
    endtask

    function automatic logic [APB_DW-1:0] reg_value(input logic [1:0] idx);
        case (idx)
            REG_TPS:  return APB_DW'(cfg_tps);
            REG_GAIN: return APB_DW'(cfg_gain);
            default:  return APB_DW'(cfg_fill);
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_pcm_result res;
        t_pcm_result want;
        logic [1:0]  idx;
        if (!i_rst_n) begin
            pcm_expected.delete();
            cfg_tps     = TPS_RST;
            cfg_gain    = GAIN_RST;
            cfg_fill    = FILL_RST;
            countdown   = 0;
            ones_sum    = 0;
            weight_sum  = 0;
            wr_ptr      = '0;
            rd_ptr      = '0;
            silence_cnt = SIL_W'(FILL_RST);
            for (int i = 0; i < FIFO_DEPTH_DEF; i++)
                level_ram[i] = '0;
            fail_count     = 0;
            window_count   = 0;
            overrun_count  = 0;
            real_count     = 0;
            sched_count    = 0;
            underrun_count = 0;
        end else begin
            idx = i_paddr[APB_AW-1:2];
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (idx)
                        REG_TPS:  cfg_tps  = i_pwdata[TPS_W-1:0];
                        REG_GAIN: cfg_gain = i_pwdata[GAIN_W-1:0];
                        REG_FILL: cfg_fill = i_pwdata[FILL_W-1:0];
                        default:  ;
                    endcase
                end else if (idx == REG_TPS || idx == REG_GAIN || idx == REG_FILL) begin
                    if (i_prdata !== reg_value(idx)) begin
                        $display("%0t: register %0d read, expected 0x%0h, actual 0x%0h",
                                 $time, idx, reg_value(idx), i_prdata);
                        fail_count++;
                    end
                end
            end

            // results first: a result never leaves in the cycle of its own request
            if (i_m_tvalid && i_m_tready) begin
                if (pcm_expected.size() == 0) begin
                    $display("%0t: unexpected result, pcm_sample %0d fill_kind %0d",
                             $time, i_m_tdata, i_m_tuser);
                    fail_count++;
                end else begin
                    want = pcm_expected.pop_front();
                    if (i_m_tdata !== {1'b0, want.pcm}) begin
                        $display("%0t: pcm_sample expected %0d, actual %0d",
                                 $time, want.pcm, i_m_tdata);
                        fail_count++;
                    end
                    if (i_m_tuser !== want.kind) begin
                        $display("%0t: fill_kind expected %0d, actual %0d",
                                 $time, want.kind, i_m_tuser);
                        fail_count++;
                    end
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser[0] == REQ_TICK) begin
                    decimate_tick(i_s_tdata[0]);
                end else begin
                    serve_request(res);
                    pcm_expected.push_back(res);
                end
            end
        end

        o_fail_count     <= fail_count;
        o_pending        <= pcm_expected.size();
        o_window_count   <= window_count;
        o_overrun_count  <= overrun_count;
        o_real_count     <= real_count;
        o_sched_count    <= sched_count;
        o_underrun_count <= underrun_count;
    end

endmodule

// ----- sim/one_bit_audio_decimator_fifo_tb.sv -----
// testbench top: reset, register writes, tick and request stimulus, verdict
`timescale 1ns / 1ps
module one_bit_audio_decimator_fifo_tb;
    import obd_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int         SETTLE_CYCLES = 40;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;

    logic                s_valid = 1'b0;
    logic [7:0]          s_data  = '0;    // [0] beeper_bit
    logic [0:0]          s_user  = '0;    // [0] req_type
    wire                 s_ready;
    logic                m_ready = 1'b0;
    wire                 m_valid;
    wire  [15:0]         m_data;          // [14:0] pcm_sample
    wire  [1:0]          m_user;          // [1:0] fill_kind

    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [APB_AW-1:0]   paddr   = '0;
    logic [APB_DW-1:0]   pwdata  = '0;
    wire  [APB_DW-1:0]   prdata;
    wire                 pready;

    int                  fail_count;
    int                  pending;
    int                  window_count;
    int                  overrun_count;
    int                  real_count;
    int                  sched_count;
    int                  underrun_count;

    int                  items_sent = 0;
    int                  stall_left = 0;
    logic                rx_steady  = 1'b0;
    logic                beep_level = 1'b0;

    one_bit_audio_decimator_fifo u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    obd_pcm_checker u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (s_valid),
        .i_s_tready       (s_ready),
        .i_s_tdata        (s_data),
        .i_s_tuser        (s_user),
        .i_m_tvalid       (m_valid),
        .i_m_tready       (m_ready),
        .i_m_tdata        (m_data),
        .i_m_tuser        (m_user),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .i_prdata         (prdata),
        .i_pready         (pready),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_window_count   (window_count),
        .o_overrun_count  (overrun_count),
        .o_real_count     (real_count),
        .o_sched_count    (sched_count),
        .o_underrun_count (underrun_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 93)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int item_gap();
        if ($urandom_range(0, 99) < 50)
            return 0;
        return random_gap();
    endfunction

    // result sink back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else if (rx_steady || $urandom_range(0, 99) < 70) begin
            m_ready <= 1'b1;
        end else begin
            stall_left = random_gap() - 1;
            m_ready <= 1'b0;
        end
    end

    task automatic send_item(input logic req, input logic [7:0] data, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= req;
        s_data  <= data;
        do @(posedge i_clk); while (!(s_valid && s_ready));
        items_sent++;
    endtask

    task automatic apb_access(input logic wr, input logic [1:0] idx,
                              input logic [APB_DW-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // wait for the block to drain, then for a window close still in flight
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // writes carry random junk above each field
    task automatic configure(input logic [TPS_W-1:0] tps, input logic [GAIN_W-1:0] gain,
                             input logic [FILL_W-1:0] fill);
        settle();
        apb_access(1'b1, REG_TPS,  ($urandom() << TPS_W)  | APB_DW'(tps));
        apb_access(1'b1, REG_GAIN, ($urandom() << GAIN_W) | APB_DW'(gain));
        apb_access(1'b1, REG_FILL, ($urandom() << FILL_W) | APB_DW'(fill));
        apb_access(1'b0, REG_TPS,  '0);
        apb_access(1'b0, REG_GAIN, '0);
        apb_access(1'b0, REG_FILL, '0);
    endtask

    task automatic run_phase(input logic [TPS_W-1:0] tps, input logic [GAIN_W-1:0] gain,
                             input logic [FILL_W-1:0] fill, input int n, input int req_pct,
                             input logic steady, input logic pause);
        logic       req;
        logic [7:0] data;
        configure(tps, gain, fill);
        rx_steady <= steady;
        for (int i = 0; i < n; i++) begin
            if (pause && i == n / 2) begin
                s_valid <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
            end
            req = ($urandom_range(0, 99) < req_pct) ? REQ_SAMPLE : REQ_TICK;
            // beeper level runs in stretches, with the odd random bit
            if ($urandom_range(0, 5) == 0)
                beep_level = ~beep_level;
            data = 8'($urandom());
            data[0] = ($urandom_range(0, 9) == 0) ? 1'($urandom()) : beep_level;
            send_item(req, data, steady ? 0 : item_gap());
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values, then a few items at the reset setting
        apb_access(1'b0, REG_TPS,  '0);
        apb_access(1'b0, REG_GAIN, '0);
        apb_access(1'b0, REG_FILL, '0);
        send_item(REQ_TICK,   8'h01, 0);
        send_item(REQ_TICK,   8'h00, 0);
        send_item(REQ_SAMPLE, 8'h01, 0);

        // zero ticks per sample is clamped to one: once the countdown is negative, every tick closes a window
        configure('0, {GAIN_W{1'b1}}, '0);
        apb_access(1'b1, REG_UNUSED, $urandom());
        apb_access(1'b0, REG_TPS, '0);
        send_item(REQ_TICK,   8'h01, 0);
        send_item(REQ_TICK,   8'h01, 0);
        send_item(REQ_TICK,   8'hFE, 0);
        send_item(REQ_TICK,   8'h00, 0);
        send_item(REQ_TICK,   8'hFF, 0);
        send_item(REQ_TICK,   8'h01, 1);
        send_item(REQ_TICK,   8'h00, 0);
        send_item(REQ_SAMPLE, 8'hFF, 0);
        send_item(REQ_SAMPLE, 8'h00, 2);
        send_item(REQ_SAMPLE, 8'h7E, 0);

        // just below one tick per sample, also clamped
        configure(24'h00FFFF, 15'h0001, 10'h001);
        send_item(REQ_TICK,   8'h01, 0);
        send_item(REQ_TICK,   8'h00, 0);
        send_item(REQ_TICK,   8'h81, 0);
        send_item(REQ_TICK,   8'h01, 0);
        send_item(REQ_SAMPLE, 8'h00, 0);
        send_item(REQ_SAMPLE, 8'h01, 0);

        // drain the start-up silence, then underruns with no fill
        run_phase(24'h008000, {GAIN_W{1'b1}}, '0, 360, 75, 1'b0, 1'b0);
        run_phase(TPS_RST, GAIN_RST, 10'd3, 60, 5, 1'b0, 1'b1);
        // ticks only at one tick per sample: the write pointer laps the read pointer
        run_phase(24'h010000, GAIN_W'($urandom()), 10'd2, 1026, 0, 1'b1, 1'b0);
        run_phase(24'h010000, GAIN_W'($urandom()), 10'd2, 30, 100, 1'b0, 1'b0);
        run_phase(TPS_W'($urandom()), GAIN_W'($urandom()), FILL_W'($urandom_range(0, 7)),
                  40, 20, 1'b0, 1'b0);
        run_phase({TPS_W{1'b1}}, GAIN_W'($urandom()), 10'd5, 40, 3, 1'b0, 1'b0);
        run_phase(TPS_W'($urandom_range(24'h010000, 24'h060000)), '0,
                  FILL_W'($urandom_range(0, 4)), 40, 30, 1'b0, 1'b0);
        run_phase(TPS_W'($urandom_range(24'h010000, 24'h060000)), GAIN_W'($urandom()),
                  FILL_W'($urandom_range(0, 4)), 40, $urandom_range(10, 40), 1'b1, 1'b0);
        run_phase(24'h018000, {GAIN_W{1'b1}}, {FILL_W{1'b1}}, 60, 50, 1'b0, 1'b0);

        settle();
        $display("covered %0d items over twelve register settings, %0d windows closed, %0d overruns",
                 items_sent, window_count, overrun_count);
        $display("results: %0d stored samples, %0d scheduled silence, %0d underrun silence",
                 real_count, sched_count, underrun_count);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- one_bit_audio_decimator_fifo.f -----
hw/rtl/obd_pkg.sv
hw/rtl/obd_regs.sv
hw/rtl/obd_level_unit.sv
hw/rtl/obd_sample_ram.sv
hw/rtl/one_bit_audio_decimator_fifo.sv
sim/obd_pcm_checker.sv
sim/one_bit_audio_decimator_fifo_tb.sv
